// ===== hw/rtl/pidl_pkg.sv =====
// shared types, codes and constants for the positional insert/delete list
package pidl_pkg;

	localparam int unsigned MAX_DEPTH = 256;
	localparam int unsigned DEF_DEPTH = 16;

	// index width that covers any entry number and any count up to MAX_DEPTH
	localparam int unsigned IDX_W = $clog2(MAX_DEPTH + 1);

	localparam int unsigned OP_W      = 2;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned CNT_OUT_W = 5;
	localparam int unsigned ST_W      = 2;

	typedef logic [OP_W-1:0] op_t;
	typedef logic [ST_W-1:0] status_t;

	localparam op_t OP_INSERT = op_t'(0);
	localparam op_t OP_DELETE = op_t'(1);
	localparam op_t OP_READ   = op_t'(2);
	localparam op_t OP_COUNT  = op_t'(3);

	localparam status_t ST_OK     = status_t'(0);
	localparam status_t ST_BADPOS = status_t'(1);
	localparam status_t ST_FULL   = status_t'(2);
	localparam status_t ST_EMPTY  = status_t'(3);

	// what every cell of the row does with its entry
	typedef enum logic [1:0] {
		CM_HOLD,
		CM_INS,
		CM_DEL,
		CM_ROT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t               mode;
		logic [IDX_W-1:0]         first_idx;
		logic [IDX_W-1:0]         last_idx;
		logic signed [VAL_W-1:0]  value;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/pidl_req_if.sv =====
// request channel: operation, position and value to insert
interface pidl_req_if import pidl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         operation;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] item_value;

	modport source (output valid, output operation, output position, output item_value,
		input ready);
	modport sink (input valid, input operation, input position, input item_value,
		output ready);
endinterface

// ===== hw/rtl/pidl_rsp_if.sv =====
// response channel: entry value, count, status and last flag
interface pidl_rsp_if import pidl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] entry_value;
	logic [CNT_OUT_W-1:0]    entries_now;
	logic [ST_W-1:0]         status;
	logic                    last;

	modport source (output valid, output entry_value, output entries_now, output status,
		output last, input ready);
	modport sink (input valid, input entry_value, input entries_now, input status,
		input last, output ready);
endinterface

// ===== hw/rtl/pidl_cell.sv =====
// one list cell: holds one entry and takes from its neighbors on shift or rotate
module pidl_cell import pidl_pkg::*; (
	input  logic                    clk,
	input  logic [IDX_W-1:0]        idx,
	input  cell_ctl_t               ctl,
	input  logic signed [VAL_W-1:0] left,
	input  logic signed [VAL_W-1:0] right,
	input  logic signed [VAL_W-1:0] head,
	output logic signed [VAL_W-1:0] data
);

	logic signed [VAL_W-1:0] data_q;
	logic signed [VAL_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.mode)
			CM_INS: begin
				if (idx > ctl.first_idx) begin
					data_d = left;
				end else if (idx == ctl.first_idx) begin
					data_d = ctl.value;
				end
			end
			CM_DEL: begin
				if (idx >= ctl.first_idx) begin
					data_d = right;
				end
			end
			CM_ROT: begin
				// entries below the last one move down, head wraps to the last
				if (idx < ctl.last_idx) begin
					data_d = right;
				end else if (idx == ctl.last_idx) begin
					data_d = head;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// ===== hw/rtl/positional_insert_delete_list_top.sv =====
// top level of the positional insert/delete list: cell row and control
//
// ordered list of up to DEPTH signed 32-bit entries held in a row of cells
// req channel: one beat carries operation, position (1-based) and item_value
//   insert puts item_value at position, later entries move up one cell
//   delete removes the entry at position, later entries move down one cell
//   read out returns every entry in order, one rsp beat each, last on the final
//   query returns the count only
// rsp channel: entry_value, entries_now, status, last; error cases give one
//   beat with entry_value zero and last set
// rsp beat of insert, delete, query or a failed read out is registered and
//   shown in the cycle after the req beat; insert and delete shift the whole
//   row at once, so a new req beat can follow whenever the rsp slot is free
// read out of n entries: the row rotates by one cell per rsp beat and the
//   head cell is sent, and req is held off meanwhile; after n beats the row
//   is back in its original order
// the rsp register frees the req side: a new req beat is taken in the same
//   cycle that the pending rsp beat leaves, or when none is pending
// a stalled rsp holds its payload; read out pauses its rotation until taken
// reset clears the count, the read out state and rsp valid; cell contents
//   are not reset and only entries below the count are ever shown
module positional_insert_delete_list_top import pidl_pkg::*; #(
	parameter int unsigned DEPTH = DEF_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	pidl_req_if.sink   req,
	pidl_rsp_if.source rsp
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned RD_W  = $clog2(DEPTH);
	// compare width that holds a position, a count and a count plus one
	localparam int unsigned CMP_W = IDX_W + 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic                    state_q, state_d;
	logic [CNT_W-1:0]        count_q, count_d;
	logic [RD_W-1:0]         rd_q, rd_d;

	logic                    rsp_valid_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CNT_OUT_W-1:0]    entries_q;
	status_t                 status_q;
	logic                    last_q;

	// next rsp beat
	logic                    ld;
	logic signed [VAL_W-1:0] ld_val;
	status_t                 ld_st;
	logic                    ld_last;

	logic                    slot_free;
	logic                    acc;
	logic [CMP_W-1:0]        pos_x;
	logic [CMP_W-1:0]        cnt_x;
	logic [CMP_W-1:0]        rd_x;

	cell_ctl_t               ctl;
	logic signed [VAL_W-1:0] cell_data [DEPTH];

	// row of cells, entry i in cell i
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [VAL_W-1:0] left_w;
		logic signed [VAL_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = cell_data[g];
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end

		if (g == DEPTH - 1) begin : g_end
			assign right_w = cell_data[g];
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end

		pidl_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(g)),
			.ctl   (ctl),
			.left  (left_w),
			.right (right_w),
			.head  (cell_data[0]),
			.data  (cell_data[g])
		);
	end

	// the rsp slot is free when empty or being emptied this cycle
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign acc       = req.valid && req.ready;

	assign pos_x = CMP_W'(req.position);
	assign cnt_x = CMP_W'(count_q);
	assign rd_x  = CMP_W'(rd_q);

	always_comb begin
		ctl.mode      = CM_HOLD;
		ctl.first_idx = IDX_W'(pos_x - CMP_W'(1));
		ctl.last_idx  = IDX_W'(cnt_x - CMP_W'(1));
		ctl.value     = req.item_value;

		ld      = 1'b0;
		ld_val  = '0;
		ld_st   = ST_OK;
		ld_last = 1'b1;
		count_d = count_q;
		state_d = state_q;
		rd_d    = rd_q;

		if (acc) begin
			ld = 1'b1;
			case (req.operation)
				OP_INSERT: begin
					// full check comes before the position check
					if (cnt_x >= CMP_W'(DEPTH)) begin
						ld_st = ST_FULL;
					end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
						ld_st = ST_BADPOS;
					end else begin
						ctl.mode = CM_INS;
						count_d  = count_q + CNT_W'(1);
					end
				end
				OP_DELETE: begin
					if (pos_x == '0 || pos_x > cnt_x) begin
						ld_st = ST_BADPOS;
					end else begin
						ctl.mode = CM_DEL;
						count_d  = count_q - CNT_W'(1);
					end
				end
				OP_READ: begin
					if (count_q == '0) begin
						ld_st = ST_EMPTY;
					end else begin
						// beats come from the read out state
						ld      = 1'b0;
						state_d = S_READ;
						rd_d    = '0;
					end
				end
				default: begin
					ld_st = ST_OK;
				end
			endcase
		end else if (state_q == S_READ && slot_free) begin
			// send the head cell and rotate the used part of the row
			ld       = 1'b1;
			ctl.mode = CM_ROT;
			ld_val   = cell_data[0];
			ld_last  = (rd_x + CMP_W'(1) == cnt_x);
			rd_d     = rd_q + RD_W'(1);
			if (ld_last) begin
				state_d = S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rd_q    <= rd_d;
			if (ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// rsp payload, no reset needed
	always_ff @(posedge clk) begin
		if (ld) begin
			val_q     <= ld_val;
			entries_q <= CNT_OUT_W'(count_d);
			status_q  <= ld_st;
			last_q    <= ld_last;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.entry_value = val_q;
	assign rsp.entries_now = entries_q;
	assign rsp.status      = status_q;
	assign rsp.last        = last_q;

	// count never goes past the row length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= CMP_W'(DEPTH))
		else $error("entry count above depth");

	// read out pointer stays inside the list
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> rd_x < cnt_x)
		else $error("read out pointer past the count");

	// a beat without last only comes from an ongoing read out
	a_last_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !last_q) |-> state_q == S_READ)
		else $error("non-final beat outside read out");

	// list length does not change during read out
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> $stable(count_q))
		else $error("count changed during read out");

	// read out of a non-empty list starts with an empty rsp slot
	a_read_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.operation == OP_READ && count_q != '0)
		|=> (state_q == S_READ && !rsp_valid_q))
		else $error("read out start out of step");

endmodule

// ===== verif/positional_insert_delete_list_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the positional insert/delete list top level
module positional_insert_delete_list_top_tb import pidl_pkg::*; ();

	localparam int unsigned LIST_DEPTH = DEF_DEPTH;

	// one request beat as the list sees it
	typedef struct {
		op_t                     op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
	} list_req_t;

	// one response beat as the list should send it
	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [CNT_OUT_W-1:0]    count;
		status_t                 status;
		logic                    last;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	pidl_req_if req_ch ();
	pidl_rsp_if rsp_ch ();

	positional_insert_delete_list_top #(.DEPTH(LIST_DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #10 clk = ~clk;

	// requests waiting for the driver, responses waiting for the monitor
	list_req_t req_backlog [$];
	list_rsp_t rsp_expected [$];
	list_rsp_t rsp_want;

	// shadow copy of the list, advanced on every accepted request beat
	logic signed [VAL_W-1:0] shadow_list [LIST_DEPTH];
	int unsigned             shadow_count;

	// count as seen while generating, and the direction random traffic leans
	int unsigned plan_count;
	bit          growing;

	// idle chances in percent, changed between phases
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	int unsigned mismatches;
	int unsigned req_beats;
	int unsigned rsp_beats;
	int unsigned full_hits;
	int unsigned badpos_hits;
	int unsigned empty_hits;
	int unsigned readout_hits;

	// expected beat carries the count after the operation
	task automatic push_rsp(input logic signed [VAL_W-1:0] value, input status_t status,
		input logic last);
		list_rsp_t r;
		r.value  = value;
		r.count  = CNT_OUT_W'(shadow_count);
		r.status = status;
		r.last   = last;
		rsp_expected.push_back(r);
	endtask

	// advance the shadow list by one request and queue what it must answer
	task automatic apply_list_op(input list_req_t r);
		int n;
		int p;
		n = int'(shadow_count);
		p = int'(r.pos);
		case (r.op)
			OP_INSERT: begin
				// a full list is reported before any position check
				if (n >= int'(LIST_DEPTH)) begin
					full_hits++;
					push_rsp('0, ST_FULL, 1'b1);
				end else if (p < 1 || p > n + 1) begin
					badpos_hits++;
					push_rsp('0, ST_BADPOS, 1'b1);
				end else begin
					for (int i = n; i > p - 1; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[p-1] = r.value;
					shadow_count = n + 1;
					push_rsp('0, ST_OK, 1'b1);
				end
			end
			OP_DELETE: begin
				// delete on an empty list lands here too
				if (p < 1 || p > n) begin
					badpos_hits++;
					push_rsp('0, ST_BADPOS, 1'b1);
				end else begin
					for (int i = p - 1; i + 1 < n; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_count = n - 1;
					push_rsp('0, ST_OK, 1'b1);
				end
			end
			OP_READ: begin
				if (n == 0) begin
					empty_hits++;
					push_rsp('0, ST_EMPTY, 1'b1);
				end else begin
					readout_hits++;
					for (int i = 0; i < n; i++)
						push_rsp(shadow_list[i], ST_OK, logic'(i + 1 == n));
				end
			end
			default: push_rsp('0, ST_OK, 1'b1);
		endcase
	endtask

	task automatic queue_req(input op_t op, input int unsigned pos,
		input logic signed [VAL_W-1:0] value);
		list_req_t r;
		r.op    = op;
		r.pos   = POS_W'(pos);
		r.value = value;
		req_backlog.push_back(r);
	endtask

	// random request: mostly legal positions, leaning toward filling or draining
	function automatic list_req_t pick_list_req();
		list_req_t   r;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (growing)
			r.op = (roll < 55) ? OP_INSERT : (roll < 70) ? OP_DELETE :
				(roll < 85) ? OP_READ : OP_COUNT;
		else
			r.op = (roll < 55) ? OP_DELETE : (roll < 70) ? OP_INSERT :
				(roll < 85) ? OP_READ : OP_COUNT;

		if ($urandom_range(0, 9) == 0 || r.op == OP_READ || r.op == OP_COUNT)
			r.pos = POS_W'($urandom_range(0, 31));
		else if (r.op == OP_INSERT)
			r.pos = POS_W'($urandom_range(1, plan_count + 1));
		else
			r.pos = (plan_count == 0) ? POS_W'(1) : POS_W'($urandom_range(1, plan_count));

		r.value = $urandom();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: r.value = 32'sh7fff_ffff;
				1: r.value = 32'sh8000_0000;
				2: r.value = '0;
				default: r.value = '1;
			endcase
		end

		// track the count the list will have, to steer positions
		if (r.op == OP_INSERT && plan_count < LIST_DEPTH && r.pos >= 1 &&
			r.pos <= plan_count + 1)
			plan_count++;
		else if (r.op == OP_DELETE && r.pos >= 1 && r.pos <= plan_count)
			plan_count--;

		// linger a little at full and at empty before turning around
		if (growing && plan_count == LIST_DEPTH && $urandom_range(0, 3) == 0)
			growing = 1'b0;
		else if (!growing && plan_count == 0 && $urandom_range(0, 3) == 0)
			growing = 1'b1;
		return r;
	endfunction

	// hold until every queued request went out and every response came back
	task automatic drain_list();
		while (req_backlog.size() != 0 || req_ch.valid || rsp_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic random_phase(input int unsigned n_items);
		plan_count = shadow_count;
		growing    = (shadow_count < LIST_DEPTH);
		repeat (n_items)
			req_backlog.push_back(pick_list_req());
		drain_list();
	endtask

	// driver: presents the next backlog item, holds it while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.operation  <= '0;
			req_ch.position   <= '0;
			req_ch.item_value <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				req_beats++;
				apply_list_op('{req_ch.operation, req_ch.position, req_ch.item_value});
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_ch.valid      <= 1'b1;
					req_ch.operation  <= req_backlog[0].op;
					req_ch.position   <= req_backlog[0].pos;
					req_ch.item_value <= req_backlog[0].value;
					void'(req_backlog.pop_front());
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure, each beat checked against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_beats++;
				if (rsp_expected.size() == 0) begin
					$error("response beat with nothing outstanding: entry_value %0d status %0d",
						rsp_ch.entry_value, rsp_ch.status);
					mismatches++;
				end else begin
					rsp_want = rsp_expected.pop_front();
					if (rsp_ch.entry_value !== rsp_want.value) begin
						$error("entry_value: expected %0d, got %0d", rsp_want.value,
							rsp_ch.entry_value);
						mismatches++;
					end
					if (rsp_ch.entries_now !== rsp_want.count) begin
						$error("entries_now: expected %0d, got %0d", rsp_want.count,
							rsp_ch.entries_now);
						mismatches++;
					end
					if (rsp_ch.status !== rsp_want.status) begin
						$error("status: expected %0d, got %0d", rsp_want.status,
							rsp_ch.status);
						mismatches++;
					end
					if (rsp_ch.last !== rsp_want.last) begin
						$error("last: expected %0d, got %0d", rsp_want.last, rsp_ch.last);
						mismatches++;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		// hold reset, then release it on a falling edge
		arst_n        = 1'b0;
		send_idle_pct = 36;
		recv_idle_pct = 87;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list: readout, delete and count
		queue_req(OP_READ, 1, '0);
		queue_req(OP_DELETE, 1, '0);
		queue_req(OP_COUNT, 0, '0);
		// positions outside the legal range, including all-zero and all-one
		queue_req(OP_INSERT, 0, 32'sd5);
		queue_req(OP_INSERT, 31, 32'sd5);
		queue_req(OP_INSERT, 2, 32'sd5);
		// build up: tail, head and middle inserts with extreme values
		queue_req(OP_INSERT, 1, 32'sh7fff_ffff);
		queue_req(OP_INSERT, 2, 32'sh8000_0000);
		queue_req(OP_INSERT, 1, -32'sd1);
		queue_req(OP_INSERT, 2, '0);
		for (int k = 0; k < int'(LIST_DEPTH) - 4; k++)
			queue_req(OP_INSERT, $urandom_range(1, 5 + k), $urandom());
		// full list: rejected insert, full readout, then deletes at the ends
		queue_req(OP_INSERT, 1, 32'sd7);
		queue_req(OP_READ, 0, '0);
		queue_req(OP_DELETE, LIST_DEPTH + 1, '0);
		queue_req(OP_DELETE, 1, '0);
		queue_req(OP_DELETE, LIST_DEPTH - 1, '0);
		queue_req(OP_COUNT, 31, '0);
		// the sender waits here until every response is back
		drain_list();

		random_phase(100);

		send_idle_pct = 87;
		recv_idle_pct = 36;
		random_phase(100);

		// back-to-back traffic on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(100);

		// let any stray beat show up before closing
		repeat (20) @(posedge clk);
		if (rsp_expected.size() != 0)
			$error("%0d expected response beats never arrived", rsp_expected.size());

		$display("run covered %0d request beats and %0d response beats, %0d full readouts",
			req_beats, rsp_beats, readout_hits);
		$display("error cases seen: list full %0d, bad position %0d, empty readout %0d",
			full_hits, badpos_hits, empty_hits);
		if (mismatches == 0 && rsp_expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
